### hdl/otok_pkg.sv
// ----------------------------------------------------------------------------
// otok_pkg
// Shared types, character codes, keyword table and decimal scale table for the
// OBJ text tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package otok_pkg;

   localparam int MAX_KEYWORD_LEN_DEF = 6;
   localparam int MAX_FRAC_DIGITS_DEF = 9;
   localparam int FRAC_BITS_DEF       = 16;

   localparam int KW_COUNT   = 10;
   localparam int KW_MAX_LEN = 6;

   localparam logic [47:0] VAL_MAX_MAG = 48'h7FFF_FFFF_FFFF;
   localparam logic [30:0] INT_MAX_MAG = 31'h7FFF_FFFF;

   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;

   typedef enum logic [4:0] {
      TOK_ERROR         = 5'd0,
      TOK_EOF           = 5'd1,
      TOK_V             = 5'd2,
      TOK_VT            = 5'd3,
      TOK_VN            = 5'd4,
      TOK_VP            = 5'd5,
      TOK_F             = 5'd6,
      TOK_O             = 5'd7,
      TOK_G             = 5'd8,
      TOK_END_STATEMENT = 5'd9,
      TOK_STRING        = 5'd10,
      TOK_INTEGER       = 5'd11,
      TOK_FLOAT         = 5'd12,
      TOK_MTLLIB        = 5'd13,
      TOK_USEMTL        = 5'd14,
      TOK_S             = 5'd15,
      TOK_SEPARATOR     = 5'd16
   } tok_kind_type;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_COMMENT,
      MODE_INT,
      MODE_FRAC,
      MODE_WORD
   } mode_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_DIV,
      FSM_OUT
   } fsm_type;

   typedef enum logic [1:0] {
      FL_NONE,
      FL_INT,
      FL_FLOAT,
      FL_WORD
   } flush_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      tok_kind_type       token_kind;
      logic signed [47:0] value;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic [29:0] dividend;
      logic [3:0]  digits;
   } div_cmd_type;

   // text byte i sits at text[8*i +: 8]
   typedef struct packed {
      logic [47:0]  text;
      logic [2:0]   len;
      tok_kind_type kind;
   } kw_entry_type;

   localparam kw_entry_type KW_TABLE [KW_COUNT] = '{
      '{text: 48'h0000_0000_0076, len: 3'd1, kind: TOK_V},
      '{text: 48'h0000_0000_7476, len: 3'd2, kind: TOK_VT},
      '{text: 48'h0000_0000_6E76, len: 3'd2, kind: TOK_VN},
      '{text: 48'h0000_0000_7076, len: 3'd2, kind: TOK_VP},
      '{text: 48'h0000_0000_0066, len: 3'd1, kind: TOK_F},
      '{text: 48'h0000_0000_006F, len: 3'd1, kind: TOK_O},
      '{text: 48'h0000_0000_0067, len: 3'd1, kind: TOK_G},
      '{text: 48'h6269_6C6C_746D, len: 3'd6, kind: TOK_MTLLIB},
      '{text: 48'h6C74_6D65_7375, len: 3'd6, kind: TOK_USEMTL},
      '{text: 48'h0000_0000_0073, len: 3'd1, kind: TOK_S}
   };

   function automatic logic [29:0] pow_ten(input logic [3:0] digits);
      logic [29:0] p;
      unique case (digits)
         4'd0:    p = 30'd1;
         4'd1:    p = 30'd10;
         4'd2:    p = 30'd100;
         4'd3:    p = 30'd1000;
         4'd4:    p = 30'd10000;
         4'd5:    p = 30'd100000;
         4'd6:    p = 30'd1000000;
         4'd7:    p = 30'd10000000;
         4'd8:    p = 30'd100000000;
         4'd9:    p = 30'd1000000000;
         default: p = 30'd1;
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

### hdl/otok_div.sv
// ----------------------------------------------------------------------------
// otok_div
// Restoring shift-subtract divider, one quotient bit per cycle. Turns the
// decimal fraction digits into binary fraction bits.
// ----------------------------------------------------------------------------
`default_nettype none

module otok_div
   import otok_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire div_cmd_type          cmd,
   output logic                      done,
   output logic [FRAC_BITS-1:0]      quotient
);

   localparam int CNTW = $clog2(FRAC_BITS);

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [CNTW-1:0]      cnt_ff, cnt_in;
   logic [29:0]          rem_ff, rem_in;
   logic [29:0]          div_ff, div_in;
   logic [FRAC_BITS-1:0] quo_ff, quo_in;

   logic [30:0] shifted;
   logic [30:0] diff;
   logic        ge;

   always_comb begin
      shifted = {rem_ff, 1'b0};
      ge      = shifted >= {1'b0, div_ff};
      diff    = shifted - {1'b0, div_ff};

      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;

      if (cmd.start) begin
         // fraction is always below 10^digits, so the quotient fits the fraction bits
         rem_in = cmd.dividend;
         div_in = pow_ten(cmd.digits);
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = ge ? diff[29:0] : shifted[29:0];
         quo_in = {quo_ff[FRAC_BITS-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNTW'(FRAC_BITS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

### hdl/otok_kw.sv
// ----------------------------------------------------------------------------
// otok_kw
// Keyword matcher: compares the identifier buffer against the keyword table
// and returns the keyword's token kind, or string.
// ----------------------------------------------------------------------------
`default_nettype none

module otok_kw
   import otok_pkg::*;
#(
   parameter int MAX_KEYWORD_LEN = MAX_KEYWORD_LEN_DEF,
   parameter int LW              = $clog2(MAX_KEYWORD_LEN + 2)
) (
   input  wire logic [MAX_KEYWORD_LEN-1:0][7:0] word_buf,
   input  wire logic [LW-1:0]                   word_len,
   output tok_kind_type                         kind
);

   logic [KW_COUNT-1:0] hit;

   always_comb begin
      for (int k = 0; k < KW_COUNT; k++) begin
         hit[k] = (word_len == LW'(KW_TABLE[k].len));
         // only bytes inside the keyword length are looked at
         for (int i = 0; i < KW_MAX_LEN; i++) begin
            if ((i < int'(KW_TABLE[k].len)) &&
                (word_buf[i] != KW_TABLE[k].text[8*i +: 8])) begin
               hit[k] = 1'b0;
            end
         end
      end
   end

   always_comb begin
      kind = TOK_STRING;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         if (hit[k]) begin
            kind = KW_TABLE[k].kind;
         end
      end
   end

endmodule

`default_nettype wire

### hdl/obj_text_tokenizer.sv
// A request that gives no float result has its first token in the output
// register in the cycle after acceptance; a float waits for the bit-serial
// fraction divider. A second token follows the first as soon as the first is
// taken. The next request is taken in the cycle its predecessor's last token
// leaves the output register, so throughput is one byte per cycle barring floats,
// second tokens or output stalls. Reset is synchronous and returns to idle lexing.
// ----------------------------------------------------------------------------
// obj_text_tokenizer
// Lexer for OBJ text: one byte per request, up to two tokens per request.
// ----------------------------------------------------------------------------
`default_nettype none

module obj_text_tokenizer
   import otok_pkg::*;
#(
   parameter int MAX_KEYWORD_LEN = MAX_KEYWORD_LEN_DEF,
   parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF,
   parameter int FRAC_BITS       = FRAC_BITS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_payload
);

   localparam int LW = $clog2(MAX_KEYWORD_LEN + 2);
   localparam int IW = $clog2(MAX_KEYWORD_LEN);
   localparam int MW = 31 + FRAC_BITS;
   localparam int CW = (MW > 48) ? MW : 48;

   fsm_type      fsm_ff, fsm_in;
   mode_type     mode_ff, mode_in;
   logic         sign_ff, sign_in;
   logic [30:0]  int_ff, int_in;
   logic [29:0]  frac_ff, frac_in;
   logic [3:0]   dig_ff, dig_in;
   logic [LW-1:0] len_ff, len_in;
   logic [MAX_KEYWORD_LEN-1:0][7:0] buf_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_ff, rsp_in;
   logic         sec_valid_ff, sec_valid_in;
   tok_kind_type sec_kind_ff, sec_kind_in;
   logic [30:0]  int_hold_ff, int_hold_in;
   logic         sign_hold_ff, sign_hold_in;

   logic          wr_en;
   logic [IW-1:0] wr_idx;
   logic [7:0]    wr_data;

   div_cmd_type          div_cmd;
   logic                 div_done;
   logic [FRAC_BITS-1:0] div_quo;
   tok_kind_type         kw_kind;

   logic         req_accept, out_take;
   logic [7:0]   c;
   logic [3:0]   digit;
   logic         is_digit, is_letter, is_blank;
   logic [34:0]  int_mul;
   logic [33:0]  frac_mul;
   logic [47:0]  int_value;
   logic [CW-1:0] mag_sum;
   logic [47:0]  mag48;
   logic [47:0]  float_value;
   flush_type    flush;
   logic         do_start;
   logic         st_have;
   tok_kind_type st_kind;
   logic         b_have;
   tok_kind_type b_kind;

   otok_div #(
      .FRAC_BITS(FRAC_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .cmd     (div_cmd),
      .done    (div_done),
      .quotient(div_quo)
   );

   otok_kw #(
      .MAX_KEYWORD_LEN(MAX_KEYWORD_LEN),
      .LW             (LW)
   ) u_kw (
      .word_buf(buf_ff),
      .word_len(len_ff),
      .kind    (kw_kind)
   );

   // value paths
   always_comb begin
      int_value   = sign_ff ? (48'd0 - 48'(int_ff)) : 48'(int_ff);
      mag_sum     = (CW'(int_hold_ff) << FRAC_BITS) + CW'(div_quo);
      mag48       = (mag_sum > CW'(VAL_MAX_MAG)) ? VAL_MAX_MAG : mag_sum[47:0];
      float_value = sign_hold_ff ? (48'd0 - mag48) : mag48;
   end

   always_comb begin
      out_take   = rsp_valid_ff && !rsp_stall;
      req_stall  = !((fsm_ff == FSM_IDLE) ||
                     ((fsm_ff == FSM_OUT) && !sec_valid_ff && !rsp_stall));
      req_accept = req_valid && !req_stall;

      c         = req_payload.char_code;
      digit     = c[3:0];
      is_digit  = (c >= 8'h30) && (c <= 8'h39);
      is_letter = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
      is_blank  = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_NL);
      int_mul   = (35'(int_ff) * 35'd10) + 35'(digit);
      frac_mul  = (34'(frac_ff) * 34'd10) + 34'(digit);

      fsm_in       = fsm_ff;
      mode_in      = mode_ff;
      sign_in      = sign_ff;
      int_in       = int_ff;
      frac_in      = frac_ff;
      dig_in       = dig_ff;
      len_in       = len_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      sec_valid_in = sec_valid_ff;
      sec_kind_in  = sec_kind_ff;
      int_hold_in  = int_hold_ff;
      sign_hold_in = sign_hold_ff;
      wr_en        = 1'b0;
      wr_idx       = '0;
      wr_data      = c;
      div_cmd.start    = 1'b0;
      div_cmd.dividend = frac_ff;
      div_cmd.digits   = dig_ff;
      flush    = FL_NONE;
      do_start = 1'b0;
      st_have  = 1'b0;
      st_kind  = TOK_ERROR;
      b_have   = 1'b0;
      b_kind   = TOK_EOF;

      unique case (fsm_ff)
         FSM_OUT: begin
            if (out_take) begin
               if (sec_valid_ff) begin
                  rsp_in.token_kind = sec_kind_ff;
                  rsp_in.value      = '0;
                  rsp_in.last       = 1'b1;
                  sec_valid_in      = 1'b0;
               end else begin
                  rsp_valid_in = 1'b0;
                  fsm_in       = FSM_IDLE;
               end
            end
         end
         FSM_DIV: begin
            if (div_done) begin
               rsp_in.token_kind = TOK_FLOAT;
               rsp_in.value      = float_value;
               rsp_in.last       = !sec_valid_ff;
               rsp_valid_in      = 1'b1;
               fsm_in            = FSM_OUT;
            end
         end
         default: begin
         end
      endcase

      if (req_accept) begin
         if (req_payload.end_of_input) begin
            unique case (mode_ff)
               MODE_INT:  flush = FL_INT;
               MODE_FRAC: flush = FL_FLOAT;
               MODE_WORD: flush = FL_WORD;
               default:   flush = FL_NONE;
            endcase
            mode_in = MODE_IDLE;
         end else begin
            unique case (mode_ff)
               MODE_COMMENT: begin
                  if (c == CH_NL) begin
                     mode_in = MODE_IDLE;
                  end
               end
               MODE_INT: begin
                  if (is_digit) begin
                     int_in = (int_mul > 35'(INT_MAX_MAG)) ? INT_MAX_MAG : int_mul[30:0];
                  end else if (c == CH_DOT) begin
                     mode_in = MODE_FRAC;
                     frac_in = '0;
                     dig_in  = '0;
                  end else begin
                     flush    = FL_INT;
                     mode_in  = MODE_IDLE;
                     do_start = 1'b1;
                  end
               end
               MODE_FRAC: begin
                  if (is_digit) begin
                     if (dig_ff < 4'(MAX_FRAC_DIGITS)) begin
                        frac_in = frac_mul[29:0];
                        dig_in  = dig_ff + 1'b1;
                     end
                  end else begin
                     flush    = FL_FLOAT;
                     mode_in  = MODE_IDLE;
                     do_start = 1'b1;
                  end
               end
               MODE_WORD: begin
                  if (is_blank) begin
                     flush    = FL_WORD;
                     mode_in  = MODE_IDLE;
                     do_start = 1'b1;
                  end else if (len_ff < LW'(MAX_KEYWORD_LEN)) begin
                     wr_en  = 1'b1;
                     wr_idx = len_ff[IW-1:0];
                     len_in = len_ff + 1'b1;
                  end else begin
                     // too long for any keyword
                     len_in = LW'(MAX_KEYWORD_LEN + 1);
                  end
               end
               default: begin
                  mode_in  = MODE_IDLE;
                  do_start = 1'b1;
               end
            endcase
         end

         if (do_start) begin
            if ((c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR)) begin
               st_have = 1'b0;
            end else if (c == CH_NL) begin
               st_have = 1'b1;
               st_kind = TOK_END_STATEMENT;
            end else if (c == CH_HASH) begin
               st_have = 1'b1;
               st_kind = TOK_END_STATEMENT;
               mode_in = MODE_COMMENT;
            end else if (c == CH_SLASH) begin
               st_have = 1'b1;
               st_kind = TOK_SEPARATOR;
            end else if (is_digit || (c == CH_MINUS)) begin
               mode_in = MODE_INT;
               sign_in = (c == CH_MINUS);
               int_in  = (c == CH_MINUS) ? 31'd0 : 31'(digit);
               frac_in = '0;
               dig_in  = '0;
            end else if (is_letter) begin
               mode_in = MODE_WORD;
               wr_en   = 1'b1;
               wr_idx  = '0;
               len_in  = LW'(1);
            end else begin
               st_have = 1'b1;
               st_kind = TOK_ERROR;
            end
         end

         b_have = req_payload.end_of_input ? 1'b1 : st_have;
         b_kind = req_payload.end_of_input ? TOK_EOF : st_kind;

         unique case (flush)
            FL_FLOAT: begin
               // operands are captured here since a new number may start now
               div_cmd.start = 1'b1;
               int_hold_in   = int_ff;
               sign_hold_in  = sign_ff;
               sec_valid_in  = b_have;
               sec_kind_in   = b_kind;
               rsp_valid_in  = 1'b0;
               fsm_in        = FSM_DIV;
            end
            FL_INT: begin
               rsp_in.token_kind = TOK_INTEGER;
               rsp_in.value      = int_value;
               rsp_in.last       = !b_have;
               rsp_valid_in      = 1'b1;
               sec_valid_in      = b_have;
               sec_kind_in       = b_kind;
               fsm_in            = FSM_OUT;
            end
            FL_WORD: begin
               rsp_in.token_kind = kw_kind;
               rsp_in.value      = '0;
               rsp_in.last       = !b_have;
               rsp_valid_in      = 1'b1;
               sec_valid_in      = b_have;
               sec_kind_in       = b_kind;
               fsm_in            = FSM_OUT;
            end
            default: begin
               sec_valid_in = 1'b0;
               if (b_have) begin
                  rsp_in.token_kind = b_kind;
                  rsp_in.value      = '0;
                  rsp_in.last       = 1'b1;
                  rsp_valid_in      = 1'b1;
                  fsm_in            = FSM_OUT;
               end else begin
                  rsp_valid_in = 1'b0;
                  fsm_in       = FSM_IDLE;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= FSM_IDLE;
         mode_ff      <= MODE_IDLE;
         sign_ff      <= 1'b0;
         int_ff       <= '0;
         frac_ff      <= '0;
         dig_ff       <= '0;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         sec_valid_ff <= 1'b0;
      end else begin
         fsm_ff       <= fsm_in;
         mode_ff      <= mode_in;
         sign_ff      <= sign_in;
         int_ff       <= int_in;
         frac_ff      <= frac_in;
         dig_ff       <= dig_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
         sec_valid_ff <= sec_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff       <= rsp_in;
      sec_kind_ff  <= sec_kind_in;
      int_hold_ff  <= int_hold_in;
      sign_hold_ff <= sign_hold_in;
      if (wr_en) begin
         buf_ff[wr_idx] <= wr_data;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

### hdl/otok_checker.sv
// ----------------------------------------------------------------------------
// otok_checker
// Port-level checks for the OBJ text tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module otok_checker
   import otok_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_payload,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_payload
);

   // a blocked response holds its value and stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> $stable(req_payload))
      else $error("request payload changed while stalled");

   // no new request while a response is blocked at the output
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> !(req_valid && !req_stall))
      else $error("request taken while output blocked");

   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.token_kind == TOK_EOF) |-> rsp_payload.last)
      else $error("eof token not marked last");

   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.token_kind != TOK_INTEGER) &&
      (rsp_payload.token_kind != TOK_FLOAT) |-> (rsp_payload.value == '0))
      else $error("nonzero value on non-number token");

endmodule

bind obj_text_tokenizer otok_checker u_otok_checker (.*);

`default_nettype wire

### test/obj_text_tokenizer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obj_text_tokenizer_test
// Feeds OBJ text one byte per request and checks every token against a
// tokenizer model kept inside the bench. Directed lines cover keywords,
// number edges, odd bytes and end marks; random OBJ-like statements with
// noise follow, with random stalls on both sides and one long output hold.
// ----------------------------------------------------------------------------

module obj_text_tokenizer_test
   import otok_pkg::*;
();

   localparam int QUIET_LIMIT = 4000;

   logic    clock;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   obj_text_tokenizer dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // tokenizer state mirrored by the bench
   mode_type    lex_mode = MODE_IDLE;
   logic        num_negative = 1'b0;
   logic [30:0] int_part = '0;
   logic [29:0] frac_part = '0;
   logic [3:0]  frac_count = '0;
   logic [7:0]  word_bytes [KW_MAX_LEN];
   logic [2:0]  word_len = '0;

   rsp_type pending_tokens [$];
   rsp_type step_tokens [$];

   int  bad_tokens = 0;
   int  counted_items = 0;
   bit  sender_gaps = 1'b1;
   bit  receiver_gaps = 1'b1;
   int  long_hold_cycles = 0;
   int  quiet_cycles = 0;

   string kw_names [10] = '{"v", "vt", "vn", "vp", "f", "o", "g", "mtllib", "usemtl", "s"};

   function automatic void note_token(input tok_kind_type kind, input logic [47:0] val);
      rsp_type t;
      t.token_kind = kind;
      t.value      = val;
      t.last       = 1'b0;
      step_tokens.insert(step_tokens.size(), t);
   endfunction

   function automatic logic [63:0] ten_power(input int digits);
      logic [63:0] p;
      int i;
      p = 64'd1;
      for (i = 0; i < digits; i++) p = p * 64'd10;
      return p;
   endfunction

   function automatic bit is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic void close_integer();
      logic [47:0] v;
      v = {17'd0, int_part};
      if (num_negative) v = -v;
      note_token(TOK_INTEGER, v);
      lex_mode = MODE_IDLE;
   endfunction

   function automatic void close_float();
      logic [63:0] mag;
      int d;
      d = (frac_count <= 9) ? int'(frac_count) : 9;
      mag = (64'(int_part) << FRAC_BITS_DEF)
            + ((64'(frac_part) << FRAC_BITS_DEF) / ten_power(d));
      if (mag > 64'(VAL_MAX_MAG)) mag = 64'(VAL_MAX_MAG);
      if (num_negative) mag = -mag;
      note_token(TOK_FLOAT, mag[47:0]);
      lex_mode = MODE_IDLE;
   endfunction

   function automatic void close_word();
      tok_kind_type kind;
      logic [47:0] txt;
      int i;
      kind = TOK_STRING;
      txt  = '0;
      if (word_len <= KW_MAX_LEN) begin
         for (i = 0; i < int'(word_len); i++) txt = {txt[39:0], word_bytes[i]};
         case (word_len)
            3'd1: begin
               case (txt[7:0])
                  "v": kind = TOK_V;
                  "f": kind = TOK_F;
                  "o": kind = TOK_O;
                  "g": kind = TOK_G;
                  "s": kind = TOK_S;
                  default: ;
               endcase
            end
            3'd2: begin
               case (txt[15:0])
                  "vt": kind = TOK_VT;
                  "vn": kind = TOK_VN;
                  "vp": kind = TOK_VP;
                  default: ;
               endcase
            end
            3'd6: begin
               case (txt)
                  "mtllib": kind = TOK_MTLLIB;
                  "usemtl": kind = TOK_USEMTL;
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
      note_token(kind, '0);
      lex_mode = MODE_IDLE;
   endfunction

   function automatic void start_byte(input logic [7:0] c);
      if (c == CH_SPACE || c == CH_TAB || c == CH_CR) return;
      if (c == CH_NL) begin
         note_token(TOK_END_STATEMENT, '0);
      end else if (c == CH_HASH) begin
         note_token(TOK_END_STATEMENT, '0);
         lex_mode = MODE_COMMENT;
      end else if (c == CH_SLASH) begin
         note_token(TOK_SEPARATOR, '0);
      end else if (is_digit(c) || c == CH_MINUS) begin
         lex_mode     = MODE_INT;
         num_negative = (c == CH_MINUS);
         int_part     = (c == CH_MINUS) ? 31'd0 : 31'(c - "0");
         frac_part    = '0;
         frac_count   = '0;
      end else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) begin
         lex_mode      = MODE_WORD;
         word_bytes[0] = c;
         word_len      = 3'd1;
      end else begin
         note_token(TOK_ERROR, '0);
      end
   endfunction

   function automatic void tokenize_byte(input req_type r);
      logic [7:0]  c;
      logic [63:0] acc;
      int i;
      step_tokens.delete();
      c   = r.char_code;
      if (r.end_of_input) begin
         case (lex_mode)
            MODE_INT:  close_integer();
            MODE_FRAC: close_float();
            MODE_WORD: close_word();
            default: ;
         endcase
         lex_mode = MODE_IDLE;
         note_token(TOK_EOF, '0);
      end else begin
         case (lex_mode)
            MODE_COMMENT: begin
               if (c == CH_NL) lex_mode = MODE_IDLE;
            end
            MODE_INT: begin
               if (is_digit(c)) begin
                  acc = 64'(int_part) * 64'd10 + 64'(c - "0");
                  int_part = (acc > 64'(INT_MAX_MAG)) ? INT_MAX_MAG : acc[30:0];
               end else if (c == CH_DOT) begin
                  lex_mode   = MODE_FRAC;
                  frac_part  = '0;
                  frac_count = '0;
               end else begin
                  close_integer();
                  start_byte(c);
               end
            end
            MODE_FRAC: begin
               if (is_digit(c)) begin
                  if (frac_count < MAX_FRAC_DIGITS_DEF) begin
                     frac_part  = 30'(64'(frac_part) * 64'd10 + 64'(c - "0"));
                     frac_count = frac_count + 4'd1;
                  end
               end else begin
                  close_float();
                  start_byte(c);
               end
            end
            MODE_WORD: begin
               if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_NL) begin
                  close_word();
                  start_byte(c);
               end else if (word_len < MAX_KEYWORD_LEN_DEF) begin
                  word_bytes[word_len] = c;
                  word_len = word_len + 3'd1;
               end else begin
                  word_len = 3'(MAX_KEYWORD_LEN_DEF + 1);
               end
            end
            default: start_byte(c);
         endcase
      end
      for (i = 0; i < step_tokens.size(); i++) begin
         if (i == step_tokens.size() - 1) step_tokens[i].last = 1'b1;
         pending_tokens.insert(pending_tokens.size(), step_tokens[i]);
      end
   endfunction

   task automatic send_request(input req_type r);
      int gap;
      gap = (sender_gaps && $urandom_range(0, 5) == 0) ? $urandom_range(1, 18) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tokenize_byte(r);
      counted_items++;
   endtask

   task automatic send_char(input logic [7:0] c);
      req_type r;
      r.char_code    = c;
      r.end_of_input = 1'b0;
      send_request(r);
   endtask

   task automatic send_end_mark();
      req_type r;
      r.char_code    = 8'($urandom_range(0, 255));
      r.end_of_input = 1'b1;
      send_request(r);
   endtask

   task automatic send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   task automatic send_blanks();
      repeat ($urandom_range(1, 2)) send_char(($urandom_range(0, 3) == 0) ? CH_TAB : CH_SPACE);
   endtask

   task automatic send_line_end();
      if ($urandom_range(0, 4) == 0) send_char(CH_CR);
      send_char(CH_NL);
   endtask

   task automatic send_digits(input int count);
      repeat (count) send_char(8'("0" + $urandom_range(0, 9)));
   endtask

   task automatic send_number(input bit allow_fraction);
      bit neg;
      int count;
      neg = ($urandom_range(0, 3) == 0);
      if (neg) send_char(CH_MINUS);
      count = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(4, 13);
      if (neg && $urandom_range(0, 15) == 0) count = 0;
      send_digits(count);
      if (allow_fraction && $urandom_range(0, 9) < 6) begin
         send_char(CH_DOT);
         send_digits(($urandom_range(0, 9) < 8) ? $urandom_range(0, 5) : $urandom_range(6, 12));
      end
   endtask

   task automatic send_name();
      logic [7:0] b;
      b = 8'(($urandom_range(0, 1) ? "a" : "A") + $urandom_range(0, 25));
      send_char(b);
      repeat ($urandom_range(0, 8)) begin
         case ($urandom_range(0, 5))
            0: begin
               b = 8'($urandom_range(0, 255));
               if (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_NL) b = "_";
            end
            1: b = 8'("0" + $urandom_range(0, 9));
            default: b = 8'("a" + $urandom_range(0, 25));
         endcase
         send_char(b);
      end
   endtask

   // one OBJ-like statement, or noise, a broken fragment or an end mark
   task automatic send_random_statement();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         send_text(kw_names[$urandom_range(0, 3)]);
         repeat ($urandom_range(1, 4)) begin
            send_blanks();
            send_number(1'b1);
         end
         send_line_end();
      end else if (pick < 60) begin
         send_text("f");
         repeat ($urandom_range(3, 4)) begin
            send_blanks();
            send_number(1'b0);
            if ($urandom_range(0, 1)) begin
               send_char(CH_SLASH);
               if ($urandom_range(0, 2) != 0) send_number(1'b0);
               if ($urandom_range(0, 1)) begin
                  send_char(CH_SLASH);
                  send_number(1'b0);
               end
            end
         end
         send_line_end();
      end else if (pick < 70) begin
         send_text(kw_names[$urandom_range(4, 9)]);
         send_blanks();
         if ($urandom_range(0, 3) == 0) send_number(1'b0);
         else send_name();
         send_line_end();
      end else if (pick < 78) begin
         send_char(CH_HASH);
         repeat ($urandom_range(0, 10)) send_char(8'($urandom_range(32, 126)));
         send_char(CH_NL);
      end else if (pick < 88) begin
         repeat ($urandom_range(1, 8)) send_char(8'($urandom_range(0, 255)));
      end else if (pick < 93) begin
         send_number(1'b1);
         send_char(8'($urandom_range(0, 255)));
      end else if (pick < 97) begin
         send_name();
         if ($urandom_range(0, 1)) send_line_end();
         else send_blanks();
      end else begin
         send_end_mark();
      end
   endtask

   task automatic test_keywords();
      send_text("v vt vn vp f o g s mtllib usemtl\n");
      send_text("mtllibs Usemtl vx\r\n");
   endtask

   task automatic test_numbers();
      send_text("0 -12 99999999999 3.25 -0.1234567890123\n");
      send_text("- -. 7/8.5//-/ 1..2 5a\n");
   endtask

   task automatic test_odd_bytes();
      send_char(8'h00);
      send_char(8'hFF);
      send_char(CH_DOT);
      send_char("!");
      send_text("ab");
      send_char(8'hFF);
      send_char(8'h00);
      send_text("cdefghij\t");
      send_text("z");
      send_char(8'h80);
      send_char(CH_NL);
   endtask

   task automatic test_end_marks();
      send_text("#abc");
      send_end_mark();
      send_text("12");
      send_end_mark();
      send_text("-1.5");
      send_end_mark();
      send_text("usemtl");
      send_end_mark();
      send_end_mark();
      send_text("# x\ng\n");
   endtask

   task automatic test_random_text(input int target);
      int start;
      start = counted_items;
      while (counted_items - start < target) send_random_statement();
   endtask

   // output held off while input keeps coming, so the block backs up
   task automatic test_output_backpressure();
      int start;
      sender_gaps      = 1'b0;
      long_hold_cycles = 300;
      start = counted_items;
      while (counted_items - start < 30) send_random_statement();
      sender_gaps = 1'b1;
   endtask

   initial begin : rsp_stall_gen
      int burst;
      burst = 0;
      forever begin
         @(negedge clock);
         if (long_hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            long_hold_cycles--;
         end else if (burst > 0) begin
            rsp_stall <= 1'b1;
            burst--;
         end else if (receiver_gaps && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            burst = $urandom_range(1, 18) - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type exp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_tokens.size() == 0) begin
            bad_tokens++;
            if (bad_tokens <= 10)
               $display("unexpected token: kind %0d value %0d last %0d",
                        rsp_payload.token_kind, rsp_payload.value, rsp_payload.last);
         end else begin
            exp = pending_tokens.pop_front();
            if (rsp_payload.token_kind !== exp.token_kind || rsp_payload.value !== exp.value
                || rsp_payload.last !== exp.last) begin
               bad_tokens++;
               if (bad_tokens <= 10)
                  $display("token mismatch: expected kind %0d value %0d last %0d,",
                           exp.token_kind, exp.value, exp.last,
                           " got kind %0d value %0d last %0d",
                           rsp_payload.token_kind, rsp_payload.value, rsp_payload.last);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_keywords();
      test_numbers();
      test_odd_bytes();
      test_end_marks();
      test_random_text(1100);
      test_output_backpressure();
      sender_gaps   = 1'b0;
      receiver_gaps = 1'b0;
      test_random_text(200);

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_tokens.size() != 0) @(posedge clock);
      repeat (FRAC_BITS_DEF + 8) @(posedge clock);
      if (bad_tokens == 0 && pending_tokens.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
